// ===== src/c8fx_pkg.sv =====
// Package for the FX opcode unit: transaction types, opcode and step codes,
// the control word layout and the microcode table. No dependencies.
package c8fx_pkg;

    localparam int NUM_VREGS = 16;

    // Opcode low bytes of the FX group, plus the two host access codes
    localparam logic [8:0] OP_LD_VX_DT = 9'h007;
    localparam logic [8:0] OP_LD_VX_K  = 9'h00A;
    localparam logic [8:0] OP_LD_DT_VX = 9'h015;
    localparam logic [8:0] OP_LD_ST_VX = 9'h018;
    localparam logic [8:0] OP_ADD_I_VX = 9'h01E;
    localparam logic [8:0] OP_LD_F_VX  = 9'h029;
    localparam logic [8:0] OP_LD_B_VX  = 9'h033;
    localparam logic [8:0] OP_LD_I_VX  = 9'h055;
    localparam logic [8:0] OP_LD_VX_I  = 9'h065;
    localparam logic [8:0] OP_HOST_WR  = 9'd256;
    localparam logic [8:0] OP_HOST_RD  = 9'd257;

    typedef struct packed {
        logic [8:0]  op;
        logic [3:0]  x;
        logic [3:0]  key_value;
        logic [11:0] host_addr;
        logic [7:0]  host_data;
    } item_t;

    typedef struct packed {
        logic [7:0]  data_out;
        logic [15:0] index_now;
        logic [15:0] pc_now;
        logic        recognized;
    } result_t;

    // Microprogram addresses
    typedef logic [4:0] upc_t;
    localparam upc_t U_END    = 5'd0;
    localparam upc_t U_NOP    = 5'd1;
    localparam upc_t U_IGN    = 5'd2;
    localparam upc_t U_F07    = 5'd3;
    localparam upc_t U_F0A    = 5'd4;
    localparam upc_t U_F15    = 5'd5;
    localparam upc_t U_F18    = 5'd6;
    localparam upc_t U_F1E    = 5'd7;
    localparam upc_t U_F29    = 5'd8;
    localparam upc_t U_F33_0  = 5'd9;
    localparam upc_t U_F33_1  = 5'd10;
    localparam upc_t U_F33_2  = 5'd11;
    localparam upc_t U_F55_L  = 5'd12;
    localparam upc_t U_F55_E  = 5'd13;
    localparam upc_t U_F65_0  = 5'd14;
    localparam upc_t U_F65_L  = 5'd15;
    localparam upc_t U_F65_E  = 5'd16;
    localparam upc_t U_HWR    = 5'd17;
    localparam upc_t U_HRD    = 5'd18;

    // Sequencing codes
    typedef logic [1:0] seq_t;
    localparam seq_t SEQ_NEXT = 2'd0;
    localparam seq_t SEQ_JUMP = 2'd1;
    localparam seq_t SEQ_LOOP = 2'd2;
    localparam seq_t SEQ_DONE = 2'd3;

    // Memory write data sources
    typedef logic [1:0] wd_t;
    localparam wd_t WD_VCNT = 2'd0;
    localparam wd_t WD_BCD  = 2'd1;
    localparam wd_t WD_HOST = 2'd2;

    // Register file write operations
    typedef logic [1:0] vop_t;
    localparam vop_t V_NONE      = 2'd0;
    localparam vop_t V_X_DELAY   = 2'd1;
    localparam vop_t V_X_KEY     = 2'd2;
    localparam vop_t V_CNT_RDATA = 2'd3;

    // Timer load operations
    typedef logic [1:0] top_t;
    localparam top_t T_NONE  = 2'd0;
    localparam top_t T_DELAY = 2'd1;
    localparam top_t T_SOUND = 2'd2;

    // Index operations
    typedef logic [1:0] iop_t;
    localparam iop_t I_NONE  = 2'd0;
    localparam iop_t I_ADD   = 2'd1;
    localparam iop_t I_GLYPH = 2'd2;
    localparam iop_t I_INC   = 2'd3;

    typedef struct packed {
        seq_t       seq;
        upc_t       target;
        logic       mem_we;
        logic       mem_re;
        logic       addr_host;
        logic [1:0] addr_off;
        wd_t        wd_sel;
        vop_t       v_op;
        top_t       t_op;
        iop_t       i_op;
        logic       cnt_inc;
        logic       pc_inc;
        logic       recog;
    } ctrl_t;

    // Entry point of the microprogram for one opcode
    function automatic upc_t dispatch(input logic [8:0] op);
        case (op)
            OP_LD_VX_DT: return U_F07;
            OP_LD_VX_K:  return U_F0A;
            OP_LD_DT_VX: return U_F15;
            OP_LD_ST_VX: return U_F18;
            OP_ADD_I_VX: return U_F1E;
            OP_LD_F_VX:  return U_F29;
            OP_LD_B_VX:  return U_F33_0;
            OP_LD_I_VX:  return U_F55_L;
            OP_LD_VX_I:  return U_F65_0;
            OP_HOST_WR:  return U_HWR;
            OP_HOST_RD:  return U_HRD;
            default:     return (op > OP_HOST_RD) ? U_IGN : U_NOP;
        endcase
    endfunction

    // Microcode table
    function automatic ctrl_t ucode(input upc_t a);
        ctrl_t c;
        c        = '0;
        c.seq    = SEQ_JUMP;
        c.target = U_END;
        case (a)
            U_END:   c.seq = SEQ_DONE;
            U_NOP:   c.pc_inc = 1'b1;
            U_IGN:   ;
            U_F07:
            begin
                c.v_op = V_X_DELAY; c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F0A:
            begin
                c.v_op = V_X_KEY; c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F15:
            begin
                c.t_op = T_DELAY; c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F18:
            begin
                c.t_op = T_SOUND; c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F1E:
            begin
                c.i_op = I_ADD; c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F29:
            begin
                c.i_op = I_GLYPH; c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F33_0:
            begin
                c.seq = SEQ_NEXT; c.mem_we = 1'b1; c.wd_sel = WD_BCD; c.addr_off = 2'd0;
            end
            U_F33_1:
            begin
                c.seq = SEQ_NEXT; c.mem_we = 1'b1; c.wd_sel = WD_BCD; c.addr_off = 2'd1;
            end
            U_F33_2:
            begin
                c.mem_we = 1'b1; c.wd_sel = WD_BCD; c.addr_off = 2'd2;
                c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F55_L:
            begin
                c.seq = SEQ_LOOP; c.target = U_F55_L;
                c.mem_we = 1'b1; c.wd_sel = WD_VCNT;
                c.i_op = I_INC; c.cnt_inc = 1'b1;
            end
            U_F55_E:
            begin
                c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_F65_0:
            begin
                c.seq = SEQ_NEXT; c.mem_re = 1'b1;
            end
            U_F65_L:
            begin
                c.seq = SEQ_LOOP; c.target = U_F65_L;
                c.mem_re = 1'b1; c.addr_off = 2'd1;
                c.v_op = V_CNT_RDATA; c.i_op = I_INC; c.cnt_inc = 1'b1;
            end
            U_F65_E:
            begin
                c.pc_inc = 1'b1; c.recog = 1'b1;
            end
            U_HWR:
            begin
                c.mem_we = 1'b1; c.addr_host = 1'b1; c.wd_sel = WD_HOST; c.recog = 1'b1;
            end
            U_HRD:
            begin
                c.mem_re = 1'b1; c.addr_host = 1'b1; c.recog = 1'b1;
            end
            default: c.seq = SEQ_DONE;
        endcase
        return c;
    endfunction

    // Three BCD digits of a byte, shift-and-add-3
    function automatic logic [11:0] bin2bcd(input logic [7:0] v);
        logic [19:0] s;
        int k;
        s = {12'b0, v};
        for (k = 0; k < 8; k++)
        begin
            if (s[11:8] >= 4'd5)
                s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5)
                s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] >= 4'd5)
                s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

endpackage

// ===== src/c8fx_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module c8fx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end

endmodule

// ===== src/chip8_fx_opcode_unit.sv =====
// Top level of the FX opcode unit: microcode sequencer and datapath.
// Depends on c8fx_pkg and c8fx_ram.
//
// Executes one FX-group instruction (or a host memory access) per transaction
// on its own V0..VF register file, index, delay and sound timers, program
// counter and byte memory. A transaction is taken at a clock edge with start
// high and busy low; its result shows on result with done high for exactly
// one cycle, and result keeps it only until the next done, so capture it then.
// A new transaction is taken only once busy has dropped again. FX33, FX55 and
// FX65 run longer, as the single memory port moves one byte per cycle. After
// reset busy stays high while a clearing pass zeroes the byte memory;
// font_base writes are taken during that pass and at any idle time.
module chip8_fx_opcode_unit #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  c8fx_pkg::item_t   item,
    output logic              done,
    output c8fx_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_data
);

    import c8fx_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // Reduce a 12-bit address into the memory depth
    function automatic logic [AW-1:0] mem_addr(input logic [11:0] a);
        logic [20:0] r;
        int k;
        r = {9'b0, a};
        for (k = 4; k >= 0; k--)
        begin
            if (r >= (21'(MEM_DEPTH) << k))
                r = r - (21'(MEM_DEPTH) << k);
        end
        return r[AW-1:0];
    endfunction

    logic          busy_reg, busy_next;
    logic          clr_reg, clr_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    upc_t          upc_reg, upc_next;
    item_t         item_reg, item_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          read_port_reg, read_port_next;
    logic          recog_reg, recog_next;
    logic [7:0]    vregs_reg [NUM_VREGS];
    logic [7:0]    vregs_next [NUM_VREGS];
    logic [15:0]   index_reg, index_next;
    logic [7:0]    delay_reg, delay_next;
    logic [7:0]    sound_reg, sound_next;
    logic [15:0]   pc_reg, pc_next;
    logic [11:0]   font_base_reg, font_base_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    ctrl_t         ctrl;
    logic          exec;
    logic [7:0]    vx;
    logic [11:0]   bcd;
    logic [15:0]   idx_addr;
    logic [11:0]   raw_addr;
    logic [7:0]    wd;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign exec = busy_reg && !clr_reg;
    assign ctrl = ucode(upc_reg);
    assign vx   = vregs_reg[item_reg.x];
    assign bcd  = bin2bcd(vx);

    // Memory address: index plus step offset (16-bit wrap) or host address
    assign idx_addr = index_reg + {14'b0, ctrl.addr_off};
    assign raw_addr = ctrl.addr_host ? item_reg.host_addr : idx_addr[11:0];

    always_comb
    begin
        case (ctrl.wd_sel)
            WD_VCNT: wd = vregs_reg[cnt_reg];
            WD_HOST: wd = item_reg.host_data;
            WD_BCD:
            begin
                case (ctrl.addr_off)
                    2'd0:    wd = {4'b0, bcd[11:8]};
                    2'd1:    wd = {4'b0, bcd[7:4]};
                    default: wd = {4'b0, bcd[3:0]};
                endcase
            end
            default: wd = 8'd0;
        endcase
    end

    // Clearing pass owns the memory port right after reset
    assign ram_we    = clr_reg || (exec && ctrl.mem_we);
    assign ram_re    = exec && ctrl.mem_re;
    assign ram_addr  = clr_reg ? clr_cnt_reg : mem_addr(raw_addr);
    assign ram_wdata = clr_reg ? 8'd0 : wd;

    c8fx_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        clr_next       = clr_reg;
        clr_cnt_next   = clr_cnt_reg;
        upc_next       = upc_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        read_port_next = read_port_reg;
        recog_next     = recog_reg;
        vregs_next     = vregs_reg;
        index_next     = index_reg;
        delay_next     = delay_reg;
        sound_next     = sound_reg;
        pc_next        = pc_reg;
        font_base_next = font_base_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        if (cfg_we)
            font_base_next = cfg_data;

        if (clr_reg)
        begin
            // Sweep the memory one byte a cycle, then release the block
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
            begin
                clr_next  = 1'b0;
                busy_next = 1'b0;
            end
        end
        else if (!busy_reg)
        begin
            if (start)
            begin
                // Latch the transaction and jump to its microprogram
                item_next      = item;
                busy_next      = 1'b1;
                upc_next       = dispatch(item.op);
                cnt_next       = 4'd0;
                read_port_next = 1'b0;
                recog_next     = 1'b0;
            end
        end
        else
        begin
            case (ctrl.v_op)
                V_X_DELAY:   vregs_next[item_reg.x] = delay_reg;
                V_X_KEY:     vregs_next[item_reg.x] = {4'b0, item_reg.key_value};
                V_CNT_RDATA: vregs_next[cnt_reg] = ram_rdata;
                default:     ;
            endcase

            case (ctrl.t_op)
                T_DELAY: delay_next = vx;
                T_SOUND: sound_next = vx;
                default: ;
            endcase

            case (ctrl.i_op)
                I_ADD:   index_next = index_reg + {8'b0, vx};
                I_GLYPH: index_next = {4'b0, font_base_reg} + {10'b0, vx[3:0], 2'b00}
                                      + {12'b0, vx[3:0]};
                I_INC:   index_next = index_reg + 16'd1;
                default: ;
            endcase

            if (ctrl.pc_inc)
                pc_next = pc_reg + 16'd2;
            if (ctrl.recog)
                recog_next = 1'b1;
            if (ctrl.mem_re && ctrl.addr_host)
                read_port_next = 1'b1;
            if (ctrl.cnt_inc)
                cnt_next = cnt_reg + 4'd1;

            case (ctrl.seq)
                SEQ_NEXT: upc_next = upc_reg + 5'd1;
                SEQ_JUMP: upc_next = ctrl.target;
                SEQ_LOOP: upc_next = (cnt_reg == item_reg.x) ? upc_reg + 5'd1 : ctrl.target;
                SEQ_DONE:
                begin
                    // Drop busy and present the state left by this transaction
                    busy_next              = 1'b0;
                    done_next              = 1'b1;
                    result_next.data_out   = read_port_reg ? ram_rdata : vx;
                    result_next.index_now  = index_reg;
                    result_next.pc_now     = pc_reg;
                    result_next.recognized = recog_reg;
                end
                default: upc_next = U_END;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            upc_reg       <= U_END;
            cnt_reg       <= 4'd0;
            read_port_reg <= 1'b0;
            recog_reg     <= 1'b0;
            vregs_reg     <= '{default: 8'd0};
            index_reg     <= 16'd0;
            delay_reg     <= 8'd0;
            sound_reg     <= 8'd0;
            pc_reg        <= 16'd512;
            font_base_reg <= 12'h050;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            read_port_reg <= read_port_next;
            recog_reg     <= recog_next;
            vregs_reg     <= vregs_next;
            index_reg     <= index_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            pc_reg        <= pc_next;
            font_base_reg <= font_base_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // A result strobe always ends an executing transaction
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg && !clr_reg))
        else $error("result strobe without an executing transaction");

    // The program counter only ever moves by one instruction
    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != $past(pc_reg)) |-> (pc_reg == 16'($past(pc_reg) + 16'd2)))
        else $error("program counter moved by other than 2");

    // Host read data selection only for a host read
    a_read_port: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && read_port_reg) |-> (item_reg.op == OP_HOST_RD))
        else $error("read port flag set for a non host read");

    // Clearing pass holds the block busy
    a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> busy_reg && !done_reg)
        else $error("block released during the clearing pass");

endmodule

// ===== dv/tb.sv =====
// Testbench for chip8_fx_opcode_unit: drives FX-group and host-memory transactions
// and checks every result against a cycle-free shadow of the unit's state.
// Depends on c8fx_pkg and the RTL of the unit; needs nothing else.
module tb;

    import c8fx_pkg::*;

    // Opcode values outside the package: the edges of the unknown subcodes and
    // of the range that the unit ignores outright
    localparam logic [8:0] OP_UNKNOWN_LO = 9'h000;
    localparam logic [8:0] OP_UNKNOWN_HI = 9'h0FF;
    localparam logic [8:0] OP_IGNORED_LO = 9'd258;
    localparam logic [8:0] OP_IGNORED_HI = 9'h1FF;

    localparam int RAM_BYTES  = 4096;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 130;
    localparam int SETTLE_CYCLES = 25;

    // Shadow of the unit: register file, memory, index, timers, program
    // counter and font base, plus the FIFO of results still to arrive.
    class fx_scoreboard;
        logic [7:0]  v_file [NUM_VREGS];
        logic [7:0]  ram [RAM_BYTES];
        logic [15:0] i_reg;
        logic [7:0]  delay_t;
        logic [7:0]  sound_t;
        logic [15:0] pc_reg;
        logic [11:0] glyph_base;
        result_t     results_due [$];
        int          errors;

        function new();
            foreach (v_file[k])
                v_file[k] = '0;
            foreach (ram[k])
                ram[k] = '0;
            i_reg      = '0;
            delay_t    = '0;
            sound_t    = '0;
            pc_reg     = 16'd512;
            glyph_base = 12'h050;
            errors     = 0;
        endfunction

        // Execute one accepted transaction on the shadow and queue its result
        function void record_issue(item_t it);
            result_t     r;
            logic [7:0]  v;
            logic [15:0] a;
            logic        known;
            logic        read_port;
            int          k;
            known     = 1'b1;
            read_port = 1'b0;
            v         = v_file[it.x];
            r.data_out = '0;
            if (it.op == OP_HOST_WR)
                ram[it.host_addr] = it.host_data;
            else if (it.op == OP_HOST_RD)
            begin
                r.data_out = ram[it.host_addr];
                read_port  = 1'b1;
            end
            else if (it.op > OP_HOST_RD)
                known = 1'b0;
            else
            begin
                case (it.op)
                    OP_LD_VX_DT: v_file[it.x] = delay_t;
                    OP_LD_VX_K:  v_file[it.x] = {4'b0, it.key_value};
                    OP_LD_DT_VX: delay_t = v;
                    OP_LD_ST_VX: sound_t = v;
                    OP_ADD_I_VX: i_reg = i_reg + {8'b0, v};
                    OP_LD_F_VX:  i_reg = {4'b0, glyph_base} + 16'd5 * {12'b0, v[3:0]};
                    OP_LD_B_VX:
                    begin
                        ram[i_reg[11:0]] = v / 8'd100;
                        a = i_reg + 16'd1;
                        ram[a[11:0]] = (v % 8'd100) / 8'd10;
                        a = i_reg + 16'd2;
                        ram[a[11:0]] = v % 8'd10;
                    end
                    OP_LD_I_VX:
                        for (k = 0; k <= it.x; k++)
                        begin
                            ram[i_reg[11:0]] = v_file[k];
                            i_reg = i_reg + 16'd1;
                        end
                    OP_LD_VX_I:
                        for (k = 0; k <= it.x; k++)
                        begin
                            v_file[k] = ram[i_reg[11:0]];
                            i_reg = i_reg + 16'd1;
                        end
                    default: known = 1'b0;
                endcase
                pc_reg = pc_reg + 16'd2;
            end
            if (!read_port)
                r.data_out = v_file[it.x];
            r.index_now  = i_reg;
            r.pc_now     = pc_reg;
            r.recognized = known;
            results_due.push_back(r);
        endfunction

        // Compare one result from the unit with the oldest queued one
        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                $error("result with none outstanding: data_out %0h index_now %0h pc_now %0h",
                       got.data_out, got.index_now, got.pc_now);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.data_out !== want.data_out)
            begin
                $error("data_out: expected %0h, got %0h", want.data_out, got.data_out);
                errors++;
            end
            if (got.index_now !== want.index_now)
            begin
                $error("index_now: expected %0h, got %0h", want.index_now, got.index_now);
                errors++;
            end
            if (got.pc_now !== want.pc_now)
            begin
                $error("pc_now: expected %0h, got %0h", want.pc_now, got.pc_now);
                errors++;
            end
            if (got.recognized !== want.recognized)
            begin
                $error("recognized: expected %0b, got %0b", want.recognized, got.recognized);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [11:0] cfg_data;

    fx_scoreboard sb = new();

    // Percent chance of an idle burst after each transaction; zero in phase 1
    // and the closing phase so the unit also sees back-to-back traffic
    int idle_pct;

    chip8_fx_opcode_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The unit holds a result only until the next one: capture every done pulse
    // at the edge that closes its cycle.
    always @(posedge clk)
    begin
        if (done === 1'b1)
            sb.check_result(result);
    end

    // Hold start and the transaction until the unit takes it (start high and
    // busy low at an edge), then record it on the shadow.
    task automatic send_item(input item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.record_issue(it);
    endtask

    task automatic issue(input logic [8:0] op, input logic [3:0] x, input logic [3:0] key,
                         input logic [11:0] addr, input logic [7:0] data);
        item_t it;
        it.op        = op;
        it.x         = x;
        it.key_value = key;
        it.host_addr = addr;
        it.host_data = data;
        send_item(it);
    endtask

    // Same, with the fields that this opcode does not use left random
    task automatic issue_op(input logic [8:0] op, input logic [3:0] x);
        issue(op, x, 4'($urandom), 12'($urandom), 8'($urandom));
    endtask

    // Drop start and wait until every queued result has come and the unit
    // is idle again
    task automatic drain();
        start <= 1'b0;
        while (sb.results_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Drop start for an idle burst of random length now and then
    task automatic maybe_idle();
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Write the font base; only called with the unit idle
    task automatic write_font_base(input logic [11:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.glyph_base = v;
    endtask

    // Pick a random transaction: mostly well-formed FX opcodes, with host
    // traffic aimed near the index so that loads see written bytes, and a
    // little noise from unknown and ignored opcodes.
    function automatic item_t pick_item();
        item_t   it;
        int      r;
        logic [8:0] fx_ops [9];
        fx_ops = '{OP_LD_VX_DT, OP_LD_VX_K, OP_LD_DT_VX, OP_LD_ST_VX, OP_ADD_I_VX,
                   OP_LD_F_VX, OP_LD_B_VX, OP_LD_I_VX, OP_LD_VX_I};
        it.x         = 4'($urandom);
        it.key_value = 4'($urandom);
        it.host_data = 8'($urandom);
        it.host_addr = $urandom_range(0, 1) ? 12'($urandom)
                                            : sb.i_reg[11:0] + 12'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 12)
            it.op = OP_HOST_WR;
        else if (r < 20)
            it.op = OP_HOST_RD;
        else if (r < 24)
            it.op = 9'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        else if (r < 27)
            it.op = 9'($urandom_range(OP_IGNORED_LO, OP_IGNORED_HI));
        else
            it.op = fx_ops[$urandom_range(0, 8)];
        return it;
    endfunction

    // Walk the index up to the top of its 16-bit range and across it, so that
    // the BCD store, the block moves and the add all wrap the index.
    task automatic climb_index();
        // Plant 0xFF under the index and load it into V0
        issue(OP_HOST_WR, 4'd0, 4'd0, sb.i_reg[11:0], 8'hFF);
        maybe_idle();
        issue_op(OP_LD_VX_I, 4'd0);
        maybe_idle();
        while (sb.i_reg < 16'hFF00)
        begin
            issue_op(OP_ADD_I_VX, 4'd0);
            maybe_idle();
        end
        while (sb.i_reg < 16'hFFF0)
        begin
            issue_op(OP_LD_I_VX, 4'd15);
            maybe_idle();
        end
        while (sb.i_reg < 16'hFFFE)
        begin
            issue_op(OP_LD_I_VX, 4'd0);
            maybe_idle();
        end
        // BCD digits land from the index up and wrap past 0xFFF to 0x000
        issue_op(OP_LD_B_VX, 4'd0);
        maybe_idle();
        issue_op(OP_ADD_I_VX, 4'd0);
        maybe_idle();
        while (sb.i_reg < 16'hFFF8)
        begin
            issue_op(OP_ADD_I_VX, 4'd0);
            maybe_idle();
        end
        issue_op($urandom_range(0, 1) ? OP_LD_I_VX : OP_LD_VX_I, 4'd15);
        maybe_idle();
    endtask

    initial
    begin
        logic [11:0] font_vals [PHASES];
        int          p;
        int          n;

        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        idle_pct = 25;
        font_vals = '{12'h000, 12'hFFF, 12'($urandom), 12'hFFB, 12'($urandom), 12'h050};

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Wait out the clearing pass, then write the font base before the
        // first transaction.
        write_font_base(12'h050);

        // Directed opening: memory extremes, every opcode, BCD of 255, glyph of
        // the largest nibble, full-width block moves, unknown and ignored codes
        issue(OP_HOST_WR, 4'd0, 4'd0, 12'h000, 8'hFF);
        issue(OP_HOST_WR, 4'd15, 4'd15, 12'hFFF, 8'h00);
        issue(OP_HOST_WR, 4'd5, 4'd10, 12'h800, 8'h7F);
        issue(OP_HOST_RD, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_HOST_RD, 4'd15, 4'd15, 12'hFFF, 8'hFF);
        issue(OP_LD_VX_I, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_B_VX, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_HOST_RD, 4'd0, 4'd0, 12'h001, 8'h00);
        issue(OP_HOST_RD, 4'd0, 4'd0, 12'h002, 8'h00);
        issue(OP_HOST_RD, 4'd0, 4'd0, 12'h003, 8'h00);
        issue(OP_LD_VX_K, 4'd15, 4'd15, 12'h000, 8'h00);
        issue(OP_LD_VX_K, 4'd1, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_DT_VX, 4'd15, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_VX_DT, 4'd2, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_ST_VX, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_I_VX, 4'd15, 4'd0, 12'h000, 8'h00);
        issue(OP_ADD_I_VX, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_F_VX, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_F_VX, 4'd1, 4'd0, 12'h000, 8'h00);
        issue(OP_LD_VX_I, 4'd15, 4'd0, 12'h000, 8'h00);
        issue(OP_UNKNOWN_LO, 4'd0, 4'd0, 12'h000, 8'h00);
        issue(OP_UNKNOWN_HI, 4'd15, 4'd15, 12'hFFF, 8'hFF);
        issue(OP_IGNORED_LO, 4'd3, 4'd0, 12'h000, 8'h00);
        issue(OP_IGNORED_HI, 4'd15, 4'd15, 12'hFFF, 8'hFF);

        // Random phases, each under its own font base. Vary the idle rate so
        // some stretches run back to back; the last phase never idles.
        for (p = 0; p < PHASES; p++)
        begin
            write_font_base(font_vals[p]);
            case (p)
                1:       idle_pct = 0;
                2:       idle_pct = 45;
                3:       idle_pct = 10;
                PHASES - 1: idle_pct = 0;
                default: idle_pct = 25;
            endcase
            if (p == 1 || p == 3)
                climb_index();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(pick_item());
                // Now and then hold off until everything in flight is back
                if (idle_pct != 0 && $urandom_range(0, 99) == 0)
                    drain();
                else
                    maybe_idle();
            end
        end

        drain();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // End the run if it hangs
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== chip8_fx_opcode_unit.f =====
src/c8fx_pkg.sv
src/c8fx_ram.sv
src/chip8_fx_opcode_unit.sv
dv/tb.sv
